// ===== rtl/core/swks_pkg.sv =====
// Package for the stack with key search: sizes, operation and status codes,
// and the word conversion used on push and search. No dependencies.
package swks_pkg;

    localparam int DEPTH      = 64;
    localparam int DATA_WIDTH = 32;
    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 6;
    localparam int FILL_W     = 7;
    localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW         = $clog2(DEPTH + 1);

    typedef logic [DATA_WIDTH-1:0] word_t;

    typedef enum logic [1:0] {
        FUNC_PUSH   = 2'd0,
        FUNC_POP    = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_CLEAR  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        ST_DONE      = 3'd0,
        ST_FULL      = 3'd1,
        ST_EMPTY     = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_MATCH     = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FLUSH
    } state_t;

    // sign-extend the input value and keep the low DATA_WIDTH bits
    function automatic word_t to_word(input logic signed [VALUE_W-1:0] v);
        logic signed [63:0] ext;
        ext = 64'(v);
        return ext[DATA_WIDTH-1:0];
    endfunction

endpackage

// ===== rtl/core/stack_with_key_search.sv =====
// Top level of the stack with key search: one synchronous entry memory,
// fill counter, search sequencer and output register. Depends on swks_pkg.

// Push, pop and clear each take one request per cycle while the result side
// accepts, and give one result. A search walks the stored entries from oldest
// to newest through the single read port of the entry memory, one entry per
// cycle unless a held match waits on a stalled result side. Its last result
// is registered as the sequencer leaves its flush state, and the next request
// can be taken once it is back in idle with the result slot free. Each match
// is held back one step so the final one can be marked last. A search of an
// empty store, or one with no match, gives one not-found result. The entry
// memory needs no clearing after reset: only entries below the fill count are
// ever read, and all of those were written by pushes.
module stack_with_key_search (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  logic [1:0]                           func,
    input  logic signed [swks_pkg::VALUE_W-1:0]  value,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    output logic [2:0]                           status,
    output logic [swks_pkg::IDX_W-1:0]           match_index,
    output logic [swks_pkg::FILL_W-1:0]          fill_count,
    output logic                                 last
);
    import swks_pkg::*;

    // entry memory
    word_t mem [DEPTH];
    word_t rd_data_reg;
    logic  rd_en;
    logic  wr_en;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    word_t wr_data;

    // control and datapath registers
    state_t state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    word_t key_reg, key_next;
    logic [CW-1:0] issue_idx_reg, issue_idx_next;
    logic chk_valid_reg, chk_valid_next;
    logic [AW-1:0] chk_idx_reg, chk_idx_next;
    logic pend_valid_reg, pend_valid_next;
    logic [AW-1:0] pend_idx_reg, pend_idx_next;

    logic out_valid_reg, out_valid_next;
    status_t status_reg, status_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic last_reg, last_next;

    logic slot_free;
    logic accept;
    logic hit;
    logic stall;
    logic more;
    func_t op;

    assign slot_free = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE) && slot_free;
    assign accept    = in_valid && in_ready;
    assign op        = func_t'(func);
    assign hit       = chk_valid_reg && (rd_data_reg == key_reg);
    assign stall     = hit && pend_valid_reg && !slot_free;
    assign more      = issue_idx_reg < count_reg;

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign match_index = idx_reg;
    assign fill_count  = fill_reg;
    assign last        = last_reg;

    // memory port: write on push, read while scanning
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign wr_en   = accept && (op == FUNC_PUSH) && (count_reg < CW'(DEPTH));
    assign wr_addr = count_reg[AW-1:0];
    assign wr_data = to_word(value);
    assign rd_en   = (state_reg == S_SCAN) && !stall && more;
    assign rd_addr = issue_idx_reg[AW-1:0];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && (op == FUNC_SEARCH))
                begin
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (!stall && !more && !chk_valid_reg)
                begin
                    state_next = S_FLUSH;
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and result register
    always_comb
    begin
        count_next      = count_reg;
        key_next        = key_reg;
        issue_idx_next  = issue_idx_reg;
        chk_valid_next  = chk_valid_reg;
        chk_idx_next    = chk_idx_reg;
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        status_next     = status_reg;
        idx_next        = idx_reg;
        fill_next       = fill_reg;
        last_next       = last_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    idx_next  = '0;
                    last_next = 1'b1;
                    case (op)
                        FUNC_PUSH:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg >= CW'(DEPTH))
                            begin
                                status_next = ST_FULL;
                                fill_next   = FILL_W'(count_reg);
                            end
                            else
                            begin
                                count_next  = count_reg + 1'b1;
                                status_next = ST_DONE;
                                fill_next   = FILL_W'(count_reg + 1'b1);
                            end
                        end
                        FUNC_POP:
                        begin
                            out_valid_next = 1'b1;
                            if (count_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                                fill_next   = '0;
                            end
                            else
                            begin
                                count_next  = count_reg - 1'b1;
                                status_next = ST_DONE;
                                fill_next   = FILL_W'(count_reg - 1'b1);
                            end
                        end
                        FUNC_SEARCH:
                        begin
                            key_next        = to_word(value);
                            issue_idx_next  = '0;
                            chk_valid_next  = 1'b0;
                            pend_valid_next = 1'b0;
                        end
                        default:
                        begin
                            out_valid_next = 1'b1;
                            count_next     = '0;
                            status_next    = ST_DONE;
                            fill_next      = '0;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (!stall)
                begin
                    // compare stage: hold each match until the next one shows
                    if (hit)
                    begin
                        if (pend_valid_reg)
                        begin
                            out_valid_next = 1'b1;
                            status_next    = ST_MATCH;
                            idx_next       = IDX_W'(pend_idx_reg);
                            fill_next      = FILL_W'(count_reg);
                            last_next      = 1'b0;
                        end
                        pend_valid_next = 1'b1;
                        pend_idx_next   = chk_idx_reg;
                    end
                    // read stage
                    chk_valid_next = more;
                    chk_idx_next   = issue_idx_reg[AW-1:0];
                    if (more)
                    begin
                        issue_idx_next = issue_idx_reg + 1'b1;
                    end
                end
            end
            S_FLUSH:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    fill_next      = FILL_W'(count_reg);
                    last_next      = 1'b1;
                    if (pend_valid_reg)
                    begin
                        status_next = ST_MATCH;
                        idx_next    = IDX_W'(pend_idx_reg);
                    end
                    else
                    begin
                        status_next = ST_NOT_FOUND;
                        idx_next    = '0;
                    end
                    pend_valid_next = 1'b0;
                end
            end
            default:
            begin
                chk_valid_next  = 1'b0;
                pend_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            count_reg      <= '0;
            chk_valid_reg  <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            chk_valid_reg  <= chk_valid_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        key_reg       <= key_next;
        issue_idx_reg <= issue_idx_next;
        chk_idx_reg   <= chk_idx_next;
        pend_idx_reg  <= pend_idx_next;
        status_reg    <= status_next;
        idx_reg       <= idx_next;
        fill_reg      <= fill_next;
        last_reg      <= last_next;
    end

endmodule

// ===== sim/stack_with_key_search_tb.sv =====
`timescale 1ns / 1ps
// Testbench for stack_with_key_search: a table of directed requests followed by
// random push/pop/search/clear traffic, all checked against an in-bench stack
// model under random stalls on both sides. Depends on swks_pkg and the RTL top.
module stack_with_key_search_tb;

    import swks_pkg::*;

    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_WAIT  = 150;
    localparam int HOLD_CYCLES = 400;
    localparam int POOL_N      = 6;

    // one expected result
    typedef struct {
        status_t              st;
        logic [IDX_W-1:0]     idx;
        logic [FILL_W-1:0]    fill;
        logic                 last;
    } result_t;

    // directed row; the typed expectation is used only when pinned is set
    typedef struct {
        func_t             f;
        logic [31:0]       v;
        bit                pinned;
        status_t           st;
        logic [FILL_W-1:0] fill;
    } dir_row_t;

    // pinned expectation that travels with each offered request
    typedef struct {
        bit                pinned;
        status_t           st;
        logic [FILL_W-1:0] fill;
    } pin_t;

    logic                        clk;
    logic                        rst_n;
    logic                        in_valid;
    logic                        in_ready;
    func_t                       func;
    logic signed [VALUE_W-1:0]   value;
    logic                        out_valid;
    logic                        out_ready;
    logic [2:0]                  status;
    logic [IDX_W-1:0]            match_index;
    logic [FILL_W-1:0]           fill_count;
    logic                        last;

    // stack model state
    word_t       shadow_words [DEPTH];
    int          shadow_fill;
    result_t     pending_results [$];
    pin_t        pin_q [$];
    dir_row_t    dir_rows [$];

    logic [31:0] word_pool [POOL_N];
    int          send_idle;
    int          recv_idle;
    logic        hold_go;
    int          errors;
    int          cycles;
    int          n_req;
    int          n_res;
    int          n_match;
    int          n_full;
    int          n_empty;
    int          n_miss;
    int          run_hits;
    int          max_hits;

    stack_with_key_search u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .func        (func),
        .value       (value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .match_index (match_index),
        .fill_count  (fill_count),
        .last        (last)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // stack model: one accepted request in, expected results queued
    function automatic void predict_stack_op(input func_t f,
                                             input logic signed [VALUE_W-1:0] v,
                                             input pin_t pin);
        result_t          r;
        result_t          prev;
        bit               have_prev;
        logic signed [63:0] wide;
        word_t            key;
        int               i;
        wide      = v;
        key       = wide[DATA_WIDTH-1:0];
        have_prev = 1'b0;
        r.st      = ST_DONE;
        r.idx     = '0;
        r.last    = 1'b1;
        case (f)
            FUNC_PUSH:
            begin
                if (shadow_fill >= DEPTH)
                    r.st = ST_FULL;
                else
                begin
                    shadow_words[shadow_fill] = key;
                    shadow_fill++;
                end
            end
            FUNC_POP:
            begin
                if (shadow_fill == 0)
                    r.st = ST_EMPTY;
                else
                    shadow_fill--;
            end
            FUNC_SEARCH:
            begin
                // hold each match back one step so the final one gets last
                for (i = 0; i < shadow_fill; i++)
                begin
                    if (shadow_words[i] == key)
                    begin
                        if (have_prev)
                            pending_results.push_back(prev);
                        prev.st   = ST_MATCH;
                        prev.idx  = i[IDX_W-1:0];
                        prev.fill = shadow_fill[FILL_W-1:0];
                        prev.last = 1'b0;
                        have_prev = 1'b1;
                    end
                end
                if (!have_prev)
                    r.st = ST_NOT_FOUND;
            end
            default:
                shadow_fill = 0;
        endcase
        r.fill = shadow_fill[FILL_W-1:0];
        if (have_prev)
        begin
            r      = prev;
            r.last = 1'b1;
        end
        if (pin.pinned)
        begin
            r.st   = pin.st;
            r.fill = pin.fill;
            r.idx  = '0;
            r.last = 1'b1;
        end
        pending_results.push_back(r);
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    // request and result monitor; prediction first so a same-edge result finds it
    always @(posedge clk)
    begin
        result_t r;
        pin_t    pin;
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                pin = pin_q.pop_front();
                predict_stack_op(func, value, pin);
                n_req++;
            end
            if (out_valid && out_ready)
            begin
                n_res++;
                if (pending_results.size() == 0)
                begin
                    $error("unexpected result: status %0d fill_count %0d", status, fill_count);
                    errors++;
                end
                else
                begin
                    r = pending_results.pop_front();
                    check_field("status", r.st, status);
                    check_field("match_index", r.idx, match_index);
                    check_field("fill_count", r.fill, fill_count);
                    check_field("last", r.last, last);
                end
                // tally what the block actually reported
                case (status)
                    ST_MATCH:     begin n_match++; run_hits++; end
                    ST_FULL:      n_full++;
                    ST_EMPTY:     n_empty++;
                    ST_NOT_FOUND: n_miss++;
                    default:      ;
                endcase
                if (last)
                begin
                    if (run_hits > max_hits)
                        max_hits = run_hits;
                    run_hits = 0;
                end
            end
        end
    end

    // result side: random stalls plus one long hold-off
    always @(posedge clk)
    begin
        static int  hold_left = 0;
        static bit  hold_used = 1'b0;
        if (hold_go && !hold_used)
        begin
            hold_left = HOLD_CYCLES;
            hold_used = 1'b1;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle);
    end

    // run-length guard
    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // offer one request and wait until it is taken
    task automatic send_req(input func_t f, input logic [31:0] v, input bit pinned,
                            input status_t st, input logic [FILL_W-1:0] fill);
        pin_t pin;
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        pin.pinned = pinned;
        pin.st     = st;
        pin.fill   = fill;
        pin_q.push_back(pin);
        in_valid <= 1'b1;
        func     <= f;
        value    <= v;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic add_row(input func_t f, input logic [31:0] v, input bit pinned,
                           input status_t st, input logic [FILL_W-1:0] fill);
        dir_row_t row;
        row.f      = f;
        row.v      = v;
        row.pinned = pinned;
        row.st     = st;
        row.fill   = fill;
        dir_rows.push_back(row);
    endtask

    // pool value pool_pct percent of the time so pushes and searches collide
    function automatic logic [31:0] pick_word(input int pool_pct);
        if ($urandom_range(99) < pool_pct)
            return word_pool[$urandom_range(POOL_N - 1)];
        return $urandom;
    endfunction

    task automatic random_mix(input int count);
        int k;
        int pick;
        for (k = 0; k < count; k++)
        begin
            pick = $urandom_range(99);
            if (pick < 42)
                send_req(FUNC_PUSH, pick_word(55), 1'b0, ST_DONE, '0);
            else if (pick < 62)
                send_req(FUNC_POP, $urandom, 1'b0, ST_DONE, '0);
            else if (pick < 96)
                send_req(FUNC_SEARCH, pick_word(65), 1'b0, ST_DONE, '0);
            else
                send_req(FUNC_CLEAR, $urandom, 1'b0, ST_DONE, '0);
        end
    endtask

    // stimulus
    initial
    begin
        int          ph;
        int          k;
        logic [31:0] fill_word;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        func        = FUNC_PUSH;
        value       = '0;
        out_ready   = 1'b0;
        hold_go     = 1'b0;
        send_idle   = 22;
        recv_idle   = 88;
        shadow_fill = 0;
        errors      = 0;
        cycles      = 0;
        n_req       = 0;
        n_res       = 0;
        n_match     = 0;
        n_full      = 0;
        n_empty     = 0;
        n_miss      = 0;
        run_hits    = 0;
        max_hits    = 0;
        for (k = 0; k < DEPTH; k++)
            shadow_words[k] = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // directed table: empty store, only-entry pop, extremes, match at index 0
        add_row(FUNC_POP,    32'h0000_0000, 1, ST_EMPTY,     7'd0);
        add_row(FUNC_SEARCH, 32'h0000_0000, 1, ST_NOT_FOUND, 7'd0);
        add_row(FUNC_CLEAR,  32'hFFFF_FFFF, 1, ST_DONE,      7'd0);
        add_row(FUNC_PUSH,   32'h0000_0005, 1, ST_DONE,      7'd1);
        add_row(FUNC_POP,    32'h0000_0000, 1, ST_DONE,      7'd0);
        add_row(FUNC_PUSH,   32'h8000_0000, 1, ST_DONE,      7'd1);
        add_row(FUNC_PUSH,   32'h7FFF_FFFF, 1, ST_DONE,      7'd2);
        add_row(FUNC_PUSH,   32'hFFFF_FFFF, 1, ST_DONE,      7'd3);
        add_row(FUNC_PUSH,   32'h0000_0000, 1, ST_DONE,      7'd4);
        add_row(FUNC_PUSH,   32'h8000_0000, 1, ST_DONE,      7'd5);
        add_row(FUNC_SEARCH, 32'h8000_0000, 0, ST_DONE,      7'd0);
        add_row(FUNC_SEARCH, 32'h7FFF_FFFF, 0, ST_DONE,      7'd0);
        add_row(FUNC_SEARCH, 32'h0000_3039, 1, ST_NOT_FOUND, 7'd5);
        add_row(FUNC_SEARCH, 32'h0000_0000, 0, ST_DONE,      7'd0);
        add_row(FUNC_SEARCH, 32'hFFFF_FFFF, 0, ST_DONE,      7'd0);
        add_row(FUNC_POP,    32'h1234_5678, 1, ST_DONE,      7'd4);
        add_row(FUNC_SEARCH, 32'h8000_0000, 0, ST_DONE,      7'd0);
        add_row(FUNC_CLEAR,  32'h0000_0000, 1, ST_DONE,      7'd0);
        add_row(FUNC_CLEAR,  32'h0000_0000, 1, ST_DONE,      7'd0);
        add_row(FUNC_PUSH,   32'hAAAA_AAAA, 1, ST_DONE,      7'd1);
        add_row(FUNC_PUSH,   32'h5555_5555, 1, ST_DONE,      7'd2);
        add_row(FUNC_SEARCH, 32'h5555_5555, 0, ST_DONE,      7'd0);
        add_row(FUNC_SEARCH, 32'hAAAA_AAAA, 0, ST_DONE,      7'd0);
        add_row(FUNC_CLEAR,  32'h0000_0000, 1, ST_DONE,      7'd0);
        foreach (dir_rows[k])
            send_req(dir_rows[k].f, dir_rows[k].v, dir_rows[k].pinned,
                     dir_rows[k].st, dir_rows[k].fill);

        // random traffic in three stall regimes
        for (ph = 0; ph < 3; ph++)
        begin
            send_idle = (ph == 0) ? 22 : (ph == 1) ? 88 : 0;
            recv_idle = (ph == 0) ? 88 : (ph == 1) ? 22 : 0;
            for (k = 0; k < POOL_N; k++)
                word_pool[k] = (k < 2) ? $urandom_range(3) : $urandom;
            random_mix(120);

            if (ph == 2)
            begin
                // fill to full behind a long result hold-off, then overflow
                hold_go   <= 1'b1;
                fill_word  = word_pool[$urandom_range(POOL_N - 1)];
                send_req(FUNC_CLEAR, $urandom, 1'b0, ST_DONE, '0);
                for (k = 0; k < DEPTH + 2; k++)
                    send_req(FUNC_PUSH, (k % 9 == 4) ? $urandom : fill_word,
                             1'b0, ST_DONE, '0);
                send_req(FUNC_SEARCH, fill_word, 1'b0, ST_DONE, '0);
                send_req(FUNC_SEARCH, pick_word(50), 1'b0, ST_DONE, '0);
                for (k = 0; k < 3; k++)
                    send_req(FUNC_POP, $urandom, 1'b0, ST_DONE, '0);
                send_req(FUNC_PUSH, fill_word, 1'b0, ST_DONE, '0);
                send_req(FUNC_SEARCH, fill_word, 1'b0, ST_DONE, '0);
                send_req(FUNC_CLEAR, $urandom, 1'b0, ST_DONE, '0);
                send_req(FUNC_POP, $urandom, 1'b0, ST_DONE, '0);
                send_req(FUNC_SEARCH, fill_word, 1'b0, ST_DONE, '0);
            end
        end
        in_valid <= 1'b0;

        // drain
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            $error("%0d expected results never arrived", pending_results.size());
            errors++;
        end

        $display("covered %0d requests, %0d results: %0d matches (up to %0d per search)",
                 n_req, n_res, n_match, max_hits);
        $display("  %0d full pushes, %0d empty pops, %0d misses, %0d errors",
                 n_full, n_empty, n_miss, errors);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
